// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk and masked during reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on aclk and masked during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/rcs_dsp_pkg.sv -----
package rcs_dsp_pkg;

    // Widths
    localparam int LINE_BITS   = 24;
    localparam int LNUM_BITS   = LINE_BITS + 1;
    localparam int COUNT_BITS  = 32;
    localparam int CMP_BITS    = (COUNT_BITS > LNUM_BITS) ? COUNT_BITS : LNUM_BITS;
    localparam int MAX_RESULTS = 3;
    localparam int RCNT_BITS   = 2;

    // Register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_LINE_COUNT = '0;

    // Input actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_COPY   = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_SKIP   = 3'd2;
    localparam logic [2:0] KIND_UNTERM = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd1;
    localparam logic [3:0] ERR_LINE_BEFORE = 4'd2;
    localparam logic [3:0] ERR_BEYOND      = 4'd3;
    localparam logic [3:0] ERR_NO_SPACE    = 4'd4;
    localparam logic [3:0] ERR_ZERO_COUNT  = 4'd5;
    localparam logic [3:0] ERR_NO_NEWLINE  = 4'd6;
    localparam logic [3:0] ERR_BAD_CMD     = 4'd7;
    localparam logic [3:0] ERR_DEL_PAST    = 4'd8;
    localparam logic [3:0] ERR_FINAL_APP   = 4'd9;

    // Script characters
    localparam logic [7:0] CH_DEL   = 8'h64;
    localparam logic [7:0] CH_APP   = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       action;
        logic [7:0] script_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [LINE_BITS-1:0] first_line;
        logic [LINE_BITS-1:0] line_count;
        logic [7:0]           data_byte;
        logic                 end_of_line;
        logic [3:0]           error_code;
        logic                 last;
    } out_word_t;

    // Results caused by one input word, in order
    typedef struct packed {
        out_word_t [MAX_RESULTS-1:0] slot;
        logic [RCNT_BITS-1:0]        count;
    } res_set_t;

    function automatic out_word_t make_result(
        input logic [2:0]           kind,
        input logic [LINE_BITS-1:0] first,
        input logic [LINE_BITS-1:0] cnt,
        input logic [7:0]           data,
        input logic                 eol,
        input logic [3:0]           err
    );
        out_word_t w;
        w.kind        = kind;
        w.first_line  = first;
        w.line_count  = cnt;
        w.data_byte   = data;
        w.end_of_line = eol;
        w.error_code  = err;
        w.last        = 1'b0;
        return w;
    endfunction

endpackage

// ----- design/rcs_delta_script_parser.sv -----
// RCS delta edit script parser.
// Script bytes enter on the s_ channel as one word each (action 0), and an
// end-of-script word (action 1) closes the script. Each word gives zero to
// three result words on the m_ channel: copy ranges, inserted bytes, skip
// ranges, an unterminated-line marker, done, or a numbered error.
// The APB port holds source_line_count at byte address 0; write it only
// while the block is idle. pready is always high.
// An accepted word waits in the input register and is parsed into the result
// register when that register can take it; its first result, if it has any,
// then raises m_valid.
// One word is accepted per cycle while each word gives at most one result and
// the receiver takes each result; a word with two or three results holds the
// input side while the receiver drains the results one word per cycle.
// When the receiver stalls, the pending results hold, the input register
// fills and s_ready drops; nothing is lost.
// Reset (aresetn low, synchronous) empties both registers, clears the parser
// and sets source_line_count to 0. An end word also clears the parser but
// keeps source_line_count.
module rcs_delta_script_parser (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [rcs_dsp_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [rcs_dsp_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [rcs_dsp_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                     pready,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  rcs_dsp_pkg::in_word_t                    s_word,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output rcs_dsp_pkg::out_word_t                   m_word
);

    logic [rcs_dsp_pkg::LINE_BITS-1:0]    src_reg;
    logic [rcs_dsp_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                                 cfg_wr;
    rcs_dsp_pkg::in_word_t                in_word_reg;
    logic                                 in_full_reg;
    logic                                 can_load;
    logic                                 advance;
    rcs_dsp_pkg::res_set_t                res;

    // Register port decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[rcs_dsp_pkg::APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (reg_idx == rcs_dsp_pkg::REG_SOURCE_LINE_COUNT) begin
            prdata = rcs_dsp_pkg::APB_DATA_BITS'(src_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= '0;
        end else if (cfg_wr && reg_idx == rcs_dsp_pkg::REG_SOURCE_LINE_COUNT) begin
            src_reg <= pwdata[rcs_dsp_pkg::LINE_BITS-1:0];
        end
    end

    // Input register: move the word on when the result register can take it
    assign advance = in_full_reg && can_load;
    assign s_ready = !in_full_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_full_reg <= 1'b1;
        end else if (advance) begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    rcs_dsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_word   (in_word_reg),
        .src_count (src_reg),
        .res       (res)
    );

    rcs_dsp_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

endmodule

// ----- design/rcs_dsp_parser.sv -----
`include "assert_macros.svh"

module rcs_dsp_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  rcs_dsp_pkg::in_word_t            in_word,
    input  logic [rcs_dsp_pkg::LINE_BITS-1:0] src_count,
    output rcs_dsp_pkg::res_set_t            res
);

    localparam int LB = rcs_dsp_pkg::LINE_BITS;
    localparam int LN = rcs_dsp_pkg::LNUM_BITS;
    localparam int CB = rcs_dsp_pkg::COUNT_BITS;
    localparam int CM = rcs_dsp_pkg::CMP_BITS;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LINE   = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;
    localparam logic [1:0] PH_INSERT = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [LN-1:0] line_reg, line_next;
    logic [CB-1:0] count_reg, count_next;
    logic [LB-1:0] copied_reg, copied_next;
    logic [CB-1:0] left_reg, left_next;
    logic          has_reg, has_next;
    logic [3:0]    sticky_reg, sticky_next;

    logic [7:0]    in_byte;
    logic [7:0]    byte_off;
    logic [3:0]    digit;
    logic          is_digit;
    logic [LN+3:0] line_x10;
    logic [LN-1:0] line_acc;
    logic [CB+3:0] count_x10;
    logic [CB-1:0] count_acc;
    logic          is_del;
    logic          is_app;
    logic          beyond;
    logic [LN-1:0] l_eff;
    logic [LN-1:0] src_ext;
    logic [LN-1:0] copied_ext;
    logic [LN-1:0] avail;
    logic [LN-1:0] gap;
    logic          copy_needed;
    logic          count_too_big;
    logic          src_more;

    // Decimal digit decode and saturating accumulate
    assign in_byte   = in_word.script_byte;
    assign byte_off  = in_byte - rcs_dsp_pkg::CH_ZERO;
    assign digit     = byte_off[3:0];
    assign is_digit  = (in_byte >= rcs_dsp_pkg::CH_ZERO) && (in_byte <= rcs_dsp_pkg::CH_NINE);
    assign line_x10  = {1'b0, line_reg, 3'b000} + {3'b000, line_reg, 1'b0}
                     + {{LN{1'b0}}, digit};
    assign line_acc  = (line_x10 > {4'b0000, {LN{1'b1}}}) ? {LN{1'b1}} : line_x10[LN-1:0];
    assign count_x10 = {1'b0, count_reg, 3'b000} + {3'b000, count_reg, 1'b0}
                     + {{CB{1'b0}}, digit};
    assign count_acc = (count_x10 > {4'b0000, {CB{1'b1}}}) ? {CB{1'b1}} : count_x10[CB-1:0];

    // Header checks
    assign is_del        = (cmd_reg == rcs_dsp_pkg::CH_DEL);
    assign is_app        = (cmd_reg == rcs_dsp_pkg::CH_APP);
    assign beyond        = is_del && (line_reg == '0);
    assign l_eff         = is_del ? (line_reg - {{(LN-1){1'b0}}, 1'b1}) : line_reg;
    assign src_ext       = {1'b0, src_count};
    assign copied_ext    = {1'b0, copied_reg};
    assign avail         = src_ext - line_reg;
    assign gap           = line_reg - copied_ext;
    assign copy_needed   = (line_reg > copied_ext);
    assign count_too_big = (CM'(count_reg) > CM'(avail));
    assign src_more      = (src_count > copied_reg);

    // Next state and results for the word in the input register
    always_comb begin
        logic [rcs_dsp_pkg::RCNT_BITS-1:0] k;
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        line_next   = line_reg;
        count_next  = count_reg;
        copied_next = copied_reg;
        left_next   = left_reg;
        has_next    = has_reg;
        sticky_next = sticky_reg;
        res         = '0;
        k           = '0;
        if (in_word.action == rcs_dsp_pkg::ACT_END) begin
            priority if (sticky_reg != rcs_dsp_pkg::ERR_NONE) begin
                res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_ERROR, '0, '0, '0,
                                                       1'b0, sticky_reg);
                k = k + 1'b1;
            end else if (phase_reg == PH_LINE || phase_reg == PH_COUNT) begin
                res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_ERROR, '0, '0, '0,
                                                       1'b0, rcs_dsp_pkg::ERR_TRUNCATED);
                k = k + 1'b1;
            end else if (phase_reg == PH_INSERT &&
                         (left_reg != {{(CB-1){1'b0}}, 1'b1} || !has_reg)) begin
                res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_ERROR, '0, '0, '0,
                                                       1'b0, rcs_dsp_pkg::ERR_FINAL_APP);
                k = k + 1'b1;
            end else begin
                if (phase_reg == PH_INSERT) begin
                    res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_UNTERM, '0, '0,
                                                           '0, 1'b0, rcs_dsp_pkg::ERR_NONE);
                    k = k + 1'b1;
                end
                if (src_more) begin
                    res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_COPY, copied_reg,
                                                           src_count - copied_reg, '0, 1'b0,
                                                           rcs_dsp_pkg::ERR_NONE);
                    k = k + 1'b1;
                end
                res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_DONE, '0, '0, '0,
                                                       1'b0, rcs_dsp_pkg::ERR_NONE);
                k = k + 1'b1;
            end
            // Return to reset state for the next script
            phase_next  = PH_IDLE;
            cmd_next    = '0;
            line_next   = '0;
            count_next  = '0;
            copied_next = '0;
            left_next   = '0;
            has_next    = 1'b0;
            sticky_next = rcs_dsp_pkg::ERR_NONE;
        end else if (sticky_reg != rcs_dsp_pkg::ERR_NONE) begin
            // Drop bytes after an error
            k = '0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    cmd_next   = in_byte;
                    line_next  = '0;
                    count_next = '0;
                    phase_next = PH_LINE;
                end
                PH_LINE: begin
                    priority if (is_digit) begin
                        line_next = line_acc;
                    end else if (!beyond && l_eff < copied_ext) begin
                        sticky_next = rcs_dsp_pkg::ERR_LINE_BEFORE;
                    end else if (beyond || l_eff > src_ext) begin
                        sticky_next = rcs_dsp_pkg::ERR_BEYOND;
                    end else if (in_byte != rcs_dsp_pkg::CH_SPACE) begin
                        sticky_next = rcs_dsp_pkg::ERR_NO_SPACE;
                    end else begin
                        line_next  = l_eff;
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    priority if (is_digit) begin
                        count_next = count_acc;
                    end else if (count_reg == '0) begin
                        sticky_next = rcs_dsp_pkg::ERR_ZERO_COUNT;
                    end else if (in_byte != rcs_dsp_pkg::CH_NL) begin
                        sticky_next = rcs_dsp_pkg::ERR_NO_NEWLINE;
                    end else if (!is_app && !is_del) begin
                        sticky_next = rcs_dsp_pkg::ERR_BAD_CMD;
                    end else if (is_del && (count_reg == {CB{1'b1}} || count_too_big)) begin
                        sticky_next = rcs_dsp_pkg::ERR_DEL_PAST;
                    end else begin
                        if (copy_needed) begin
                            res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_COPY,
                                copied_reg, gap[LB-1:0], '0, 1'b0, rcs_dsp_pkg::ERR_NONE);
                            k = k + 1'b1;
                        end
                        if (is_app) begin
                            copied_next = line_reg[LB-1:0];
                            left_next   = count_reg;
                            has_next    = 1'b0;
                            phase_next  = PH_INSERT;
                        end else begin
                            res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_SKIP,
                                line_reg[LB-1:0], count_reg[LB-1:0], '0, 1'b0,
                                rcs_dsp_pkg::ERR_NONE);
                            k = k + 1'b1;
                            copied_next = line_reg[LB-1:0] + count_reg[LB-1:0];
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                PH_INSERT: begin
                    res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_INSERT, '0, '0,
                        in_byte, in_byte == rcs_dsp_pkg::CH_NL, rcs_dsp_pkg::ERR_NONE);
                    k = k + 1'b1;
                    if (in_byte == rcs_dsp_pkg::CH_NL) begin
                        has_next  = 1'b0;
                        left_next = left_reg - {{(CB-1){1'b0}}, 1'b1};
                        if (left_reg == {{(CB-1){1'b0}}, 1'b1}) begin
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        has_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
            // Report a new error on the byte that sets it
            if (sticky_next != rcs_dsp_pkg::ERR_NONE) begin
                res.slot[k] = rcs_dsp_pkg::make_result(rcs_dsp_pkg::KIND_ERROR, '0, '0, '0,
                                                       1'b0, sticky_next);
                k = k + 1'b1;
            end
        end
        // Flag the final result of this word
        if (k != '0) begin
            res.slot[k - 1'b1].last = 1'b1;
        end
        res.count = k;
    end

    // Commit parser state when the word moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            cmd_reg    <= '0;
            line_reg   <= '0;
            count_reg  <= '0;
            copied_reg <= '0;
            left_reg   <= '0;
            has_reg    <= 1'b0;
            sticky_reg <= rcs_dsp_pkg::ERR_NONE;
        end else if (advance) begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            line_reg   <= line_next;
            count_reg  <= count_next;
            copied_reg <= copied_next;
            left_reg   <= left_next;
            has_reg    <= has_next;
            sticky_reg <= sticky_next;
        end
    end

    `ASSERT_NEXT(a_end_clears, advance && in_word.action == rcs_dsp_pkg::ACT_END,
                 phase_reg == PH_IDLE && sticky_reg == rcs_dsp_pkg::ERR_NONE)
    `ASSERT_SAME(a_quiet_after_err,
                 advance && in_word.action == rcs_dsp_pkg::ACT_BYTE &&
                 sticky_reg != rcs_dsp_pkg::ERR_NONE,
                 res.count == '0)

endmodule

// ----- design/rcs_dsp_outq.sv -----
`include "assert_macros.svh"

module rcs_dsp_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  rcs_dsp_pkg::res_set_t  res,
    output logic                   can_load,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rcs_dsp_pkg::out_word_t m_word
);

    rcs_dsp_pkg::out_word_t [rcs_dsp_pkg::MAX_RESULTS-1:0] slot_reg;
    logic [rcs_dsp_pkg::RCNT_BITS-1:0] n_reg;
    logic [rcs_dsp_pkg::RCNT_BITS-1:0] head_reg;
    logic [rcs_dsp_pkg::RCNT_BITS-1:0] head_inc;

    // Pending results run from head up to count
    assign head_inc = head_reg + 1'b1;
    assign m_valid  = (head_reg != n_reg);
    assign can_load = !m_valid || (m_ready && head_inc == n_reg);

    // Select the word at the head
    always_comb begin
        m_word = '0;
        for (int i = 0; i < rcs_dsp_pkg::MAX_RESULTS; i++) begin
            if (head_reg == i[rcs_dsp_pkg::RCNT_BITS-1:0]) begin
                m_word = slot_reg[i];
            end
        end
    end

    // Results hold their payload; no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res.slot;
        end
    end

    // Load a new set, or advance on each taken word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            head_reg <= '0;
        end else if (load) begin
            n_reg    <= res.count;
            head_reg <= '0;
        end else if (m_valid && m_ready) begin
            head_reg <= head_inc;
        end
    end

    `ASSERT_SAME(a_last_on_final, m_valid && m_word.last, head_inc == n_reg)
    `ASSERT_SAME(a_no_overwrite, load && m_valid, m_ready && m_word.last)

endmodule
